// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro names the clock and the active-low reset so that the checker
// states the sampling explicitly at every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pmd_pkg.sv =====
package pmd_pkg;

    localparam int COORD_BITS  = 12;
    localparam int SCREEN_BITS = 13;

    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd768;
    localparam logic [1:0]             RES_RESET    = 2'd2;
    localparam logic [2:0]             RATE_RESET   = 3'd6;

    // Register indexes on the configuration port (word address).
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RESOLUTION    = 2'd2;
    localparam logic [1:0] REG_SAMPLE_RATE   = 2'd3;

    // Command kinds on the input channel.
    localparam logic [2:0] KIND_RESET    = 3'd0;
    localparam logic [2:0] KIND_DEFAULTS = 3'd1;
    localparam logic [2:0] KIND_REPORT   = 3'd2;
    localparam logic [2:0] KIND_GET_ID   = 3'd3;
    localparam logic [2:0] KIND_RATE     = 3'd4;
    localparam logic [2:0] KIND_RES      = 3'd5;

    // Bytes of the mouse protocol.
    localparam logic [7:0] BYTE_ACK      = 8'hFA;
    localparam logic [7:0] BYTE_BAT_OK   = 8'hAA;
    localparam logic [7:0] CODE_RESET    = 8'hFF;
    localparam logic [7:0] CODE_DEFAULTS = 8'hF6;
    localparam logic [7:0] CODE_REPORT   = 8'hF4;
    localparam logic [7:0] CODE_GET_ID   = 8'hF2;
    localparam logic [7:0] CODE_RATE     = 8'hF3;
    localparam logic [7:0] CODE_RES      = 8'hE8;

    typedef enum logic [1:0] {
        CMD_RX,
        CMD_START,
        CMD_SET_X,
        CMD_SET_Y
    } cmd_t;

    typedef enum logic [3:0] {
        PEND_NONE,
        PEND_RESET,
        PEND_DEFAULT,
        PEND_REPORT,
        PEND_GETID,
        PEND_RATE,
        PEND_RATE_ARG,
        PEND_RES,
        PEND_RES_ARG
    } pend_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [7:0]            rx_byte;
        logic [2:0]            command_kind;
        logic [COORD_BITS-1:0] position_value;
    } in_item_t;

    typedef struct packed {
        logic                  tx_valid;
        logic [7:0]            tx_byte;
        logic [COORD_BITS-1:0] cursor_x;
        logic [COORD_BITS-1:0] cursor_y;
        logic                  button_left;
        logic                  button_right;
        logic                  button_middle;
        logic                  packet_applied;
        logic                  packet_dropped;
        logic [7:0]            device_id;
        logic                  command_busy;
    } out_item_t;

    // Sample rate argument; indexes past the table use the last entry.
    function automatic logic [7:0] rate_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'd10;
            3'd1:    r = 8'd20;
            3'd2:    r = 8'd40;
            3'd3:    r = 8'd60;
            3'd4:    r = 8'd80;
            3'd5:    r = 8'd100;
            default: r = 8'd200;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kind_code(input logic [2:0] kind);
        logic [7:0] r;
        case (kind)
            KIND_RESET:    r = CODE_RESET;
            KIND_DEFAULTS: r = CODE_DEFAULTS;
            KIND_REPORT:   r = CODE_REPORT;
            KIND_GET_ID:   r = CODE_GET_ID;
            KIND_RATE:     r = CODE_RATE;
            KIND_RES:      r = CODE_RES;
            default:       r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic pend_t kind_pend(input logic [2:0] kind);
        pend_t r;
        case (kind)
            KIND_RESET:    r = PEND_RESET;
            KIND_DEFAULTS: r = PEND_DEFAULT;
            KIND_REPORT:   r = PEND_REPORT;
            KIND_GET_ID:   r = PEND_GETID;
            KIND_RATE:     r = PEND_RATE;
            KIND_RES:      r = PEND_RES;
            default:       r = PEND_NONE;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ps2_mouse_packet_decoder_top.sv =====
// An item accepted into the input register is decoded by the single pass between
// registers, which loads its result into the output register and raises out_valid.
// Throughput: one item per cycle while out_stall does not hold the output register.
// Reset (rst_n low, asynchronous): pipeline empty, all tracking state zero,
// screen 1024 x 768, resolution code 2, sample rate index 6.
module ps2_mouse_packet_decoder_top (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  pmd_pkg::in_item_t         in_data,

    output logic                      out_valid,
    input  logic                      out_stall,
    output pmd_pkg::out_item_t        out_data,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int CB       = pmd_pkg::COORD_BITS;
    localparam int SB       = pmd_pkg::SCREEN_BITS;
    // Room for a coordinate plus or minus an 8-bit delta, with a sign bit.
    localparam int SUM_BITS = CB + 3;
    localparam logic [CB-1:0] COORD_MASK = {CB{1'b1}};

    // Stages of the reset reply: ack, self-test pass, device id, done.
    localparam logic [2:0] STG_START = 3'd0;
    localparam logic [2:0] STG_ACKED = 3'd1;
    localparam logic [2:0] STG_BAT   = 3'd2;
    localparam logic [2:0] STG_ID    = 3'd3;
    localparam logic [2:0] STG_DONE  = 3'd4;

    // Clamp a moved coordinate into [0, size-1], and into the coordinate
    // range when the screen is larger than it. A zero size pins it at 0.
    function automatic logic [CB-1:0] clamp_axis(input logic [SUM_BITS-1:0] v,
                                                 input logic [SB-1:0] size);
        logic [SB-1:0] lim_wide;
        logic [CB-1:0] lim;
        logic [CB-1:0] r;
        lim_wide = size - 1'b1;
        if (lim_wide > SB'(COORD_MASK)) begin
            lim = COORD_MASK;
        end
        else begin
            lim = lim_wide[CB-1:0];
        end
        if (size == '0) begin
            r = '0;
        end
        else if (v[SUM_BITS-1]) begin
            r = '0;
        end
        else if (v > SUM_BITS'(lim)) begin
            r = lim;
        end
        else begin
            r = v[CB-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase;
    // the port never inserts wait states.
    // ------------------------------------------------------------------
    logic [SB-1:0] width_reg;
    logic [SB-1:0] height_reg;
    logic [1:0]    res_reg;
    logic [2:0]    rate_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= pmd_pkg::WIDTH_RESET;
            height_reg <= pmd_pkg::HEIGHT_RESET;
            res_reg    <= pmd_pkg::RES_RESET;
            rate_reg   <= pmd_pkg::RATE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                pmd_pkg::REG_SCREEN_WIDTH:  width_reg  <= pwdata[SB-1:0];
                pmd_pkg::REG_SCREEN_HEIGHT: height_reg <= pwdata[SB-1:0];
                pmd_pkg::REG_RESOLUTION:    res_reg    <= pwdata[1:0];
                pmd_pkg::REG_SAMPLE_RATE:   rate_reg   <= pwdata[2:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            pmd_pkg::REG_SCREEN_WIDTH:  prdata = 32'(width_reg);
            pmd_pkg::REG_SCREEN_HEIGHT: prdata = 32'(height_reg);
            pmd_pkg::REG_RESOLUTION:    prdata = 32'(res_reg);
            pmd_pkg::REG_SAMPLE_RATE:   prdata = 32'(rate_reg);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Two-register pipeline. The input register holds one item; the decode
    // pass runs on it and commits the tracking state at the same edge that
    // loads its result into the output register. The input side keeps
    // accepting while the output register waits, until both are full.
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    pmd_pkg::in_item_t   s1_item_reg;
    logic                out_valid_reg;
    pmd_pkg::out_item_t  out_item_reg;
    logic                out_load;
    logic                commit;

    assign out_load  = !out_valid_reg || !out_stall;
    assign commit    = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tracking state: command reply progress and packet framing.
    // ------------------------------------------------------------------
    pmd_pkg::pend_t  pend_reg,  pend_next;
    logic [2:0]      stage_reg, stage_next;
    logic [7:0]      id_reg,    id_next;
    logic [1:0]      bpos_reg,  bpos_next;
    logic [7:0]      flags_reg, flags_next;
    logic [7:0]      dx_reg,    dx_next;
    logic [7:0]      dy_reg,    dy_next;
    logic            drop_reg,  drop_next;
    logic [CB-1:0]   posx_reg,  posx_next;
    logic [CB-1:0]   posy_reg,  posy_next;
    logic [2:0]      btn_reg,   btn_next;

    pmd_pkg::out_item_t  result;
    logic                tx_v;
    logic [7:0]          tx_b;
    logic                applied;
    logic                dropped;
    logic                done;
    logic [7:0]          b;
    logic [7:0]          dy_use;
    logic [SUM_BITS-1:0] vx;
    logic [SUM_BITS-1:0] vy;

    assign b = s1_item_reg.rx_byte;

    always_comb
    begin
        pend_next  = pend_reg;
        stage_next = stage_reg;
        id_next    = id_reg;
        bpos_next  = bpos_reg;
        flags_next = flags_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        drop_next  = drop_reg;
        posx_next  = posx_reg;
        posy_next  = posy_reg;
        btn_next   = btn_reg;
        tx_v       = 1'b0;
        tx_b       = 8'h00;
        applied    = 1'b0;
        dropped    = 1'b0;
        done       = 1'b0;

        // The Y delta of a 3- or 4-byte packet arrives in the third byte; when
        // that byte finishes the packet, it is used before it is stored.
        dy_use = (bpos_reg == 2'd2) ? b : dy_reg;
        vx = SUM_BITS'(posx_reg) + {{(SUM_BITS-8){dx_reg[7]}}, dx_reg};
        vy = SUM_BITS'(posy_reg) - {{(SUM_BITS-8){dy_use[7]}}, dy_use};

        unique case (s1_item_reg.cmd)
            pmd_pkg::CMD_RX:
            begin
                if (pend_reg != pmd_pkg::PEND_NONE)
                begin
                    unique case (pend_reg)
                        pmd_pkg::PEND_RESET:
                        begin
                            // Stage 4 keeps the command pending until another
                            // one is started.
                            if (b == pmd_pkg::BYTE_ACK)
                            begin
                                if (stage_reg <= STG_ID)
                                begin
                                    stage_next = stage_reg + 3'd1;
                                end
                            end
                            else if (b == pmd_pkg::BYTE_BAT_OK && stage_reg <= STG_ACKED)
                            begin
                                stage_next = STG_BAT;
                            end
                            else if (stage_reg == STG_BAT)
                            begin
                                stage_next = STG_ID;
                                id_next    = b;
                            end
                            else if (stage_reg == STG_ID)
                            begin
                                stage_next = STG_DONE;
                                pend_next  = pmd_pkg::PEND_NONE;
                            end
                        end
                        pmd_pkg::PEND_RATE:
                        begin
                            if (b == pmd_pkg::BYTE_ACK)
                            begin
                                pend_next = pmd_pkg::PEND_RATE_ARG;
                                tx_v      = 1'b1;
                                tx_b      = pmd_pkg::rate_byte(rate_reg);
                            end
                            else
                            begin
                                pend_next = pmd_pkg::PEND_NONE;
                            end
                        end
                        pmd_pkg::PEND_RES:
                        begin
                            if (b == pmd_pkg::BYTE_ACK)
                            begin
                                pend_next = pmd_pkg::PEND_RES_ARG;
                                tx_v      = 1'b1;
                                tx_b      = {6'b0, res_reg};
                            end
                            else
                            begin
                                pend_next = pmd_pkg::PEND_NONE;
                            end
                        end
                        pmd_pkg::PEND_GETID:
                        begin
                            if (b != pmd_pkg::BYTE_ACK)
                            begin
                                id_next = b;
                            end
                            pend_next = pmd_pkg::PEND_NONE;
                        end
                        default:
                        begin
                            pend_next = pmd_pkg::PEND_NONE;
                        end
                    endcase
                end
                else
                begin
                    case (bpos_reg)
                        2'd0:
                        begin
                            // A first byte without its always-one bit is not a
                            // packet start; framing waits for the next byte.
                            flags_next = b;
                            drop_next  = b[7] | b[6];
                            bpos_next  = b[3] ? 2'd1 : 2'd0;
                        end
                        2'd1:
                        begin
                            dx_next   = b;
                            bpos_next = 2'd2;
                        end
                        2'd2:
                        begin
                            dy_next = b;
                            if (id_reg == 8'h00)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                bpos_next = 2'd3;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase

                    if (done)
                    begin
                        bpos_next = 2'd0;
                        if (drop_reg)
                        begin
                            drop_next = 1'b0;
                            dropped   = 1'b1;
                        end
                        else
                        begin
                            posx_next = clamp_axis(vx, width_reg);
                            posy_next = clamp_axis(vy, height_reg);
                            btn_next  = flags_reg[2:0];
                            applied   = 1'b1;
                        end
                    end
                end
            end
            pmd_pkg::CMD_START:
            begin
                // Kinds past the table are ignored and send nothing.
                if (s1_item_reg.command_kind <= pmd_pkg::KIND_RES)
                begin
                    pend_next = pmd_pkg::kind_pend(s1_item_reg.command_kind);
                    if (s1_item_reg.command_kind == pmd_pkg::KIND_RESET)
                    begin
                        stage_next = STG_START;
                    end
                    tx_v = 1'b1;
                    tx_b = pmd_pkg::kind_code(s1_item_reg.command_kind);
                end
            end
            pmd_pkg::CMD_SET_X:
            begin
                posx_next = s1_item_reg.position_value;
            end
            pmd_pkg::CMD_SET_Y:
            begin
                posy_next = s1_item_reg.position_value;
            end
            default:
            begin
            end
        endcase

        result.tx_valid       = tx_v;
        result.tx_byte        = tx_b;
        result.cursor_x       = posx_next;
        result.cursor_y       = posy_next;
        result.button_left    = btn_next[0];
        result.button_right   = btn_next[1];
        result.button_middle  = btn_next[2];
        result.packet_applied = applied;
        result.packet_dropped = dropped;
        result.device_id      = id_next;
        result.command_busy   = (pend_next != pmd_pkg::PEND_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= pmd_pkg::PEND_NONE;
            stage_reg <= STG_START;
            id_reg    <= '0;
            bpos_reg  <= '0;
            flags_reg <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            drop_reg  <= 1'b0;
            posx_reg  <= '0;
            posy_reg  <= '0;
            btn_reg   <= '0;
        end
        else if (commit)
        begin
            pend_reg  <= pend_next;
            stage_reg <= stage_next;
            id_reg    <= id_next;
            bpos_reg  <= bpos_next;
            flags_reg <= flags_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            drop_reg  <= drop_next;
            posx_reg  <= posx_next;
            posy_reg  <= posy_next;
            btn_reg   <= btn_next;
        end
    end

    // Payload registers carry no reset; their valid bits guard them.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_item_reg <= in_data;
        end
        if (commit)
        begin
            out_item_reg <= result;
        end
    end

endmodule

// ===== rtl/pmd_checker.sv =====
`include "assert_macros.svh"

module pmd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input pmd_pkg::out_item_t  out_data
);

    // A result waiting on a stalled output stays put.
    `PMD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result item changed")

    // No byte is reported for the mouse unless one is to be sent.
    `PMD_ASSERT_SAME(a_tx_zero, clk, rst_n, out_valid && !out_data.tx_valid, out_data.tx_byte == 8'h00, "tx_byte set without tx_valid")

    // A packet ends either applied or dropped, never both.
    `PMD_ASSERT_SAME(a_pkt_excl, clk, rst_n, out_valid, !(out_data.packet_applied && out_data.packet_dropped), "packet both applied and dropped")

    // Packets are framed only with no command pending, and they send nothing.
    `PMD_ASSERT_SAME(a_pkt_idle, clk, rst_n, out_valid && (out_data.packet_applied || out_data.packet_dropped), !out_data.command_busy && !out_data.tx_valid, "packet completed during a command")

endmodule

bind ps2_mouse_packet_decoder_top pmd_checker u_pmd_checker (.*);
